### rtl/pcxd_pkg.sv
package pcxd_pkg;

	localparam int DATA_W  = 8;
	localparam int PIX_W   = 4;
	localparam int RUN_W   = 6;
	localparam int CFG_W   = 16;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;
	localparam int MAX_RUN_DEF = 63;

	localparam logic [1:0] RUN_TAG = 2'b11;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_LINE_BYTES   = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [CFG_W-1:0] image_width;
		logic [CFG_W-1:0] image_height;
		logic [CFG_W-1:0] line_bytes;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic run_start;
		logic step_end;
	} status_t;

endpackage

### rtl/pcxd_regs.sv
module pcxd_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pcxd_pkg::APB_AW-1:0] paddr,
	input  logic [pcxd_pkg::APB_DW-1:0] pwdata,
	output logic [pcxd_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output pcxd_pkg::cfg_t              cfg
);
	import pcxd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= CFG_W'(1);
			cfg_q.image_height <= CFG_W'(1);
			cfg_q.line_bytes   <= CFG_W'(1);
		end else if (wr_en) begin
			case (idx)
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[CFG_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[CFG_W-1:0];
				REG_LINE_BYTES:   cfg_q.line_bytes   <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_IMAGE_WIDTH:  prdata = APB_DW'(cfg_q.image_width);
			REG_IMAGE_HEIGHT: prdata = APB_DW'(cfg_q.image_height);
			REG_LINE_BYTES:   prdata = APB_DW'(cfg_q.line_bytes);
			default:          prdata = '0;
		endcase
	end

endmodule

### rtl/pcxd_datapath.sv
module pcxd_datapath #(
	parameter int MAX_RUN = pcxd_pkg::MAX_RUN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pcxd_pkg::cfg_t              cfg,
	input  pcxd_pkg::cmd_t              cmd,
	output pcxd_pkg::status_t           status,
	input  logic [pcxd_pkg::DATA_W-1:0] data_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pcxd_pkg::PIX_W-1:0]  pixel,
	output logic                        last,
	output logic                        row_end,
	output logic                        image_end
);
	import pcxd_pkg::*;

	logic              expect_q;
	logic              finished_q;
	logic [RUN_W-1:0]  run_len_q;
	logic [RUN_W-1:0]  cnt_q;
	logic [DATA_W-1:0] val_q;
	logic [CFG_W-1:0]  col_q;
	logic [CFG_W-1:0]  row_q;

	logic              hold_v_q;
	logic [PIX_W-1:0]  hold_pix_q;
	logic              hold_re_q;
	logic              hold_ie_q;

	logic              out_v_q;
	logic [PIX_W-1:0]  out_pix_q;
	logic              out_last_q;
	logic              out_re_q;
	logic              out_ie_q;

	logic [CFG_W-1:0]  w;
	logic [CFG_W-1:0]  h;
	logic [CFG_W-1:0]  len_raw;
	logic [CFG_W-1:0]  len;
	logic              out_free;
	logic              is_hdr;
	logic              lit_en;
	logic              dec_en;
	logic [DATA_W-1:0] dec_val;
	logic              made;
	logic              re;
	logic              ie;
	logic [CFG_W:0]    col_inc;
	logic              wrap;
	logic [RUN_W-1:0]  hdr_cnt;

	assign w       = (cfg.image_width == '0) ? CFG_W'(1) : cfg.image_width;
	assign h       = (cfg.image_height == '0) ? CFG_W'(1) : cfg.image_height;
	assign len_raw = (cfg.line_bytes == '0) ? CFG_W'(1) : cfg.line_bytes;
	assign len     = (len_raw < w) ? w : len_raw;

	assign out_free = !out_v_q || !out_stall;
	assign is_hdr   = (data_byte[DATA_W-1:DATA_W-2] == RUN_TAG);
	assign lit_en   = cmd.accept && !finished_q && !expect_q && !is_hdr;
	assign dec_en   = lit_en || cmd.step;
	assign dec_val  = cmd.step ? val_q : data_byte;

	assign made    = (col_q < w);
	assign re      = (col_q == (w - CFG_W'(1)));
	assign ie      = re && (row_q == (h - CFG_W'(1)));
	assign col_inc = {1'b0, col_q} + (CFG_W+1)'(1);
	assign wrap    = (col_inc >= {1'b0, len});

	assign hdr_cnt = (data_byte[RUN_W-1:0] > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN)
		: data_byte[RUN_W-1:0];

	assign status.out_free  = out_free;
	assign status.run_start = !finished_q && expect_q && (run_len_q != '0);
	assign status.step_end  = (cnt_q == RUN_W'(1)) || (made && ie);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q   <= 1'b0;
			finished_q <= 1'b0;
			run_len_q  <= '0;
			cnt_q      <= '0;
			col_q      <= '0;
			row_q      <= '0;
			hold_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cmd.accept && !finished_q) begin
				if (expect_q) begin
					expect_q  <= 1'b0;
					cnt_q     <= run_len_q;
					run_len_q <= '0;
				end else if (is_hdr) begin
					expect_q  <= 1'b1;
					run_len_q <= hdr_cnt;
				end
			end
			if (cmd.step) begin
				cnt_q <= cnt_q - RUN_W'(1);
			end
			if (dec_en) begin
				if (made && ie) begin
					finished_q <= 1'b1;
				end
				if (wrap) begin
					col_q <= '0;
					row_q <= row_q + CFG_W'(1);
				end else begin
					col_q <= col_inc[CFG_W-1:0];
				end
			end
			if (cmd.step && made) begin
				hold_v_q <= 1'b1;
			end else if (cmd.flush) begin
				hold_v_q <= 1'b0;
			end
			if ((lit_en && made) || (cmd.step && made && hold_v_q)
				|| (cmd.flush && hold_v_q)) begin
				out_v_q <= 1'b1;
			end else if (out_free) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && expect_q) begin
			val_q <= data_byte;
		end
		if (cmd.step && made) begin
			hold_pix_q <= dec_val[PIX_W-1:0];
			hold_re_q  <= re;
			hold_ie_q  <= ie;
		end
		if (lit_en && made) begin
			out_pix_q  <= dec_val[PIX_W-1:0];
			out_last_q <= 1'b1;
			out_re_q   <= re;
			out_ie_q   <= ie;
		end else if ((cmd.step && made && hold_v_q) || (cmd.flush && hold_v_q)) begin
			out_pix_q  <= hold_pix_q;
			out_last_q <= cmd.flush;
			out_re_q   <= hold_re_q;
			out_ie_q   <= hold_ie_q;
		end
	end

	assign out_valid = out_v_q;
	assign pixel     = out_pix_q;
	assign last      = out_last_q;
	assign row_end   = out_re_q;
	assign image_end = out_ie_q;

`ifndef SYNTHESIS
	a_step_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.flush) |-> out_free)
		else $error("run step or flush issued while the output word is blocked");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (cnt_q != '0))
		else $error("run step issued with no repeats left");

	a_finished_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("image completion flag cleared without reset");

	a_image_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_ie_q) |-> finished_q)
		else $error("image end word shown before the image is marked complete");
`endif

endmodule

### rtl/pcxd_ctrl.sv
module pcxd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pcxd_pkg::status_t   status,
	output pcxd_pkg::cmd_t      cmd
);
	import pcxd_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		cmd.accept = 1'b0;
		cmd.step   = 1'b0;
		cmd.flush  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall   = !status.out_free;
				cmd.accept = in_valid && status.out_free;
				if (cmd.accept && status.run_start) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.step = status.out_free;
				if (cmd.step && status.step_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				cmd.flush = status.out_free;
				if (cmd.flush) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/pcx_rle_pixel_decoder_unit.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   data_byte[7:0]
// output    out        out_valid / out_stall pixel[3:0], last, row_end, image_end
// config    in         APB write, pready=1   image_width, image_height, line_bytes
//
// A literal or header byte is accepted directly in the idle state. A run value byte is
// accepted, then the run sequencer steps once per repeat and closes with a flush step.
// The column and row counters step once per literal byte and once per run repeat.
// Reset clears the decoder state and sets every config register to 1.
// A stalled output word holds the run sequencer and the input side.
module pcx_rle_pixel_decoder_unit #(
	parameter int MAX_RUN = pcxd_pkg::MAX_RUN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pcxd_pkg::APB_AW-1:0] paddr,
	input  logic [pcxd_pkg::APB_DW-1:0] pwdata,
	output logic [pcxd_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [pcxd_pkg::DATA_W-1:0] data_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pcxd_pkg::PIX_W-1:0]  pixel,
	output logic                        last,
	output logic                        row_end,
	output logic                        image_end
);
	import pcxd_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	pcxd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pcxd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pcxd_datapath #(
		.MAX_RUN (MAX_RUN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.status    (status),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel     (pixel),
		.last      (last),
		.row_end   (row_end),
		.image_end (image_end)
	);

endmodule
